[rtl/bti_pkg.sv]
// Shared types and codes for the breakpoint table interpolator.
package bti_pkg;

    typedef enum logic [1:0] {
        FUNC_WR_BP    = 2'd0,
        FUNC_WR_SHOCK = 2'd1,
        FUNC_WR_REACT = 2'd2,
        FUNC_QUERY    = 2'd3
    } func_t;

    localparam logic [1:0] STATUS_INSIDE = 2'd0;
    localparam logic [1:0] STATUS_BELOW  = 2'd1;
    localparam logic [1:0] STATUS_ABOVE  = 2'd2;

    // Classified request handed from front to back.
    // data is the write value or the query speed; last_row is rows in use, saturated to [2, ROWS], minus one.
    typedef struct packed {
        func_t       func;
        logic [3:0]  row;
        logic [2:0]  col;
        logic [31:0] data;
        logic [4:0]  last_row;
    } cmd_t;

    typedef struct packed {
        logic [31:0] shock;
        logic [31:0] react;
        logic [1:0]  status;
    } res_t;

endpackage

[rtl/breakpoint_table_interpolator.sv]
// Top level of the breakpoint table interpolator: register, queues, front and back.
//
// Usage:
//   Input channel (push/full): each request carries func, row, column, value
//   and speed. func selects a breakpoint write, a shock or reacted table write,
//   or a query. Writes give no result; a write outside the table is dropped.
//   Result channel (empty/pop): one result per query, oldest first, with the
//   interpolated shock_temp, react_temp (unsigned Q16.16) and a status.
//   Config channel (cfg_valid/cfg_ready): cfg_data sets rows_in_use; always
//   ready, to be written only while the block is idle.
// Timing:
//   A write is stored in the back end as it leaves the request queue. After
//   leaving that queue a query passes the breakpoint scan, which reads one
//   row a cycle until it stops, the divider, which makes one quotient bit a
//   cycle for a 16-bit quotient, and one multiplier, which forms the four
//   blend products. Clamped queries skip the divider.
//   A two-entry request queue lets new requests in while a query runs; a
//   two-entry result queue holds results while the receiver stalls, and the
//   back end waits when that queue is full.
// Reset: queues empty, rows_in_use = 16; table contents are kept until written.
module breakpoint_table_interpolator #(
    parameter int ROWS    = 16,
    parameter int COLUMNS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [3:0]  row,
    input  logic [2:0]  column,
    input  logic [31:0] value,
    input  logic [31:0] speed,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] shock_temp,
    output logic [31:0] react_temp,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);
    import bti_pkg::*;

    logic [4:0] rows_in_use_reg;

    // front to request queue
    logic cmd_push;
    logic cmd_full;
    cmd_t cmd_in;

    // request queue to back
    logic cmd_pop;
    logic cmd_empty;
    cmd_t cmd_out;

    // back to result queue
    logic res_push;
    logic res_full;
    res_t res_in;
    res_t res_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= 5'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rows_in_use_reg <= cfg_data;
        end
    end

    bti_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .push        (push),
        .full        (full),
        .func        (func),
        .row         (row),
        .column      (column),
        .value       (value),
        .speed       (speed),
        .rows_in_use (rows_in_use_reg),
        .cmd_push    (cmd_push),
        .cmd_full    (cmd_full),
        .cmd         (cmd_in)
    );

    bti_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    bti_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    bti_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign shock_temp = res_out.shock;
    assign react_temp = res_out.react;
    assign status     = res_out.status;

    // back end never drops a result into a full queue
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into full result queue");

    // back end only takes requests that are present
    a_cmd_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("request taken from empty request queue");

    // a waiting result is not lost while the receiver stalls
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("pending result vanished without pop");

endmodule

[rtl/bti_fifo.sv]
// Small first-in first-out queue built from registers.
module bti_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/bti_front.sv]
// Front end: accepts input requests, drops out-of-range writes, clamps query fields.
module bti_front #(
    parameter int ROWS    = 16,
    parameter int COLUMNS = 8
) (
    input  logic          push,
    output logic          full,
    input  logic [1:0]    func,
    input  logic [3:0]    row,
    input  logic [2:0]    column,
    input  logic [31:0]   value,
    input  logic [31:0]   speed,
    input  logic [4:0]    rows_in_use,
    output logic          cmd_push,
    input  logic          cmd_full,
    output bti_pkg::cmd_t cmd
);
    import bti_pkg::*;

    logic  accept;
    logic  row_ok;
    logic  col_ok;
    logic  keep;
    func_t fcode;
    int    n_sat;

    assign fcode  = func_t'(func);
    assign accept = push && !cmd_full;
    assign full   = cmd_full;
    assign row_ok = int'(row) < ROWS;
    assign col_ok = int'(column) < COLUMNS;

    always_comb
    begin
        case (fcode)
            FUNC_WR_BP:                  keep = row_ok;
            FUNC_WR_SHOCK, FUNC_WR_REACT: keep = row_ok && col_ok;
            FUNC_QUERY:                  keep = 1'b1;
            default:                     keep = 1'b0;
        endcase
    end

    // search span: rows in use saturated to [2, ROWS]
    always_comb
    begin
        if (int'(rows_in_use) < 2)
        begin
            n_sat = 2;
        end
        else if (int'(rows_in_use) > ROWS)
        begin
            n_sat = ROWS;
        end
        else
        begin
            n_sat = int'(rows_in_use);
        end
    end

    always_comb
    begin
        cmd.func     = fcode;
        cmd.row      = row;
        cmd.col      = (col_ok || fcode != FUNC_QUERY) ? column : 3'(COLUMNS - 1);
        cmd.data     = (fcode == FUNC_QUERY) ? speed : value;
        cmd.last_row = 5'(n_sat - 1);
    end

    assign cmd_push = accept && keep;

endmodule

[rtl/bti_back.sv]
// Back end: table memories, breakpoint scan, serial divider and blend sequencer.
module bti_back #(
    parameter int ROWS    = 16,
    parameter int COLUMNS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  bti_pkg::cmd_t cmd,
    input  logic          res_full,
    output logic          res_push,
    output bti_pkg::res_t res
);
    import bti_pkg::*;

    localparam int RW = $clog2(ROWS);
    localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_BP0   = 11'b00000000010,
        S_CHK0  = 11'b00000000100,
        S_SCAN  = 11'b00000001000,
        S_DIV   = 11'b00000010000,
        S_TA    = 11'b00000100000,
        S_TB    = 11'b00001000000,
        S_TWAIT = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_ACC   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] bp_mem    [ROWS];
    logic [31:0] shock_mem [ROWS][COLUMNS];
    logic [31:0] react_mem [ROWS][COLUMNS];
    logic [31:0] bp_q_reg;
    logic [31:0] shock_q_reg;
    logic [31:0] react_q_reg;

    logic [31:0] speed_reg;
    logic [31:0] lo_reg;
    logic [31:0] divisor_reg;
    logic [31:0] rem_reg;
    logic [15:0] quo_reg;
    logic [3:0]  bit_cnt_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] last_reg;
    logic [RW-1:0] idx_reg;
    logic [RW-1:0] row_a_reg;
    logic [RW-1:0] row_b_reg;
    logic [1:0]  status_reg;
    logic [31:0] shock_a_reg, shock_b_reg, react_a_reg, react_b_reg;
    logic [48:0] prod_reg;
    logic [48:0] acc_shock_reg, acc_react_reg;
    logic [1:0]  k_reg;

    logic          bp_we, shock_we, react_we;
    logic [RW-1:0] wr_row;
    logic [CW-1:0] wr_col;
    logic [RW-1:0] bp_raddr;
    logic [RW-1:0] tab_row;
    logic [32:0]   rem_sh;
    logic          rem_ge;
    logic [16:0]   weight;
    logic [31:0]   operand;

    assign cmd_pop  = (state_reg == S_IDLE) && !cmd_empty;
    assign bp_we    = cmd_pop && (cmd.func == FUNC_WR_BP);
    assign shock_we = cmd_pop && (cmd.func == FUNC_WR_SHOCK);
    assign react_we = cmd_pop && (cmd.func == FUNC_WR_REACT);
    assign wr_row   = RW'(cmd.row);
    assign wr_col   = CW'(cmd.col);

    always_comb
    begin
        case (state_reg)
            S_CHK0:  bp_raddr = RW'(1);
            S_SCAN:  bp_raddr = idx_reg + 1'b1;
            default: bp_raddr = '0;
        endcase
    end

    assign tab_row = (state_reg == S_TB) ? row_b_reg : row_a_reg;

    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_mem[wr_row] <= cmd.data;
        end
        bp_q_reg <= bp_mem[bp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (shock_we)
        begin
            shock_mem[wr_row][wr_col] <= cmd.data;
        end
        shock_q_reg <= shock_mem[tab_row][col_reg];
    end

    always_ff @(posedge clk)
    begin
        if (react_we)
        begin
            react_mem[wr_row][wr_col] <= cmd.data;
        end
        react_q_reg <= react_mem[tab_row][col_reg];
    end

    // one restoring step per cycle; remainder always below the divisor
    assign rem_sh = {rem_reg, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, divisor_reg};

    assign weight = k_reg[0] ? {1'b0, quo_reg} : (17'h10000 - {1'b0, quo_reg});

    always_comb
    begin
        case (k_reg)
            2'd0:    operand = shock_a_reg;
            2'd1:    operand = shock_b_reg;
            2'd2:    operand = react_a_reg;
            default: operand = react_b_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop && cmd.func == FUNC_QUERY)
                begin
                    state_next = S_BP0;
                end
            end
            S_BP0:   state_next = S_CHK0;
            S_CHK0:  state_next = (speed_reg < bp_q_reg) ? S_TA : S_SCAN;
            S_SCAN:
            begin
                if (bp_q_reg > speed_reg)
                begin
                    state_next = S_DIV;
                end
                else if (idx_reg == last_reg)
                begin
                    state_next = S_TA;
                end
            end
            S_DIV:   state_next = (bit_cnt_reg == 4'd15) ? S_TA : S_DIV;
            S_TA:    state_next = S_TB;
            S_TB:    state_next = S_TWAIT;
            S_TWAIT: state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = (k_reg == 2'd3) ? S_OUT : S_MUL;
            S_OUT:   state_next = res_full ? S_OUT : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                speed_reg <= cmd.data;
                col_reg   <= CW'(cmd.col);
                last_reg  <= RW'(cmd.last_row);
            end
            S_CHK0:
            begin
                if (speed_reg < bp_q_reg)
                begin
                    row_a_reg  <= '0;
                    row_b_reg  <= '0;
                    quo_reg    <= '0;
                    status_reg <= STATUS_BELOW;
                end
                else
                begin
                    lo_reg  <= bp_q_reg;
                    idx_reg <= RW'(1);
                end
            end
            S_SCAN:
            begin
                if (bp_q_reg > speed_reg)
                begin
                    divisor_reg <= bp_q_reg - lo_reg;
                    rem_reg     <= speed_reg - lo_reg;
                    quo_reg     <= '0;
                    bit_cnt_reg <= '0;
                    row_a_reg   <= idx_reg - 1'b1;
                    row_b_reg   <= idx_reg;
                    status_reg  <= STATUS_INSIDE;
                end
                else if (idx_reg == last_reg)
                begin
                    row_a_reg  <= last_reg;
                    row_b_reg  <= last_reg;
                    quo_reg    <= '0;
                    status_reg <= STATUS_ABOVE;
                end
                else
                begin
                    lo_reg  <= bp_q_reg;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                rem_reg     <= rem_ge ? 32'(rem_sh - {1'b0, divisor_reg}) : rem_sh[31:0];
                quo_reg     <= {quo_reg[14:0], rem_ge};
                bit_cnt_reg <= bit_cnt_reg + 1'b1;
            end
            S_TB:
            begin
                shock_a_reg <= shock_q_reg;
                react_a_reg <= react_q_reg;
            end
            S_TWAIT:
            begin
                shock_b_reg   <= shock_q_reg;
                react_b_reg   <= react_q_reg;
                acc_shock_reg <= 49'd32768;
                acc_react_reg <= 49'd32768;
                k_reg         <= '0;
            end
            S_MUL:
            begin
                prod_reg <= 49'(weight) * 49'(operand);
            end
            S_ACC:
            begin
                if (!k_reg[1])
                begin
                    acc_shock_reg <= acc_shock_reg + prod_reg;
                end
                else
                begin
                    acc_react_reg <= acc_react_reg + prod_reg;
                end
                k_reg <= k_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign res_push   = (state_reg == S_OUT) && !res_full;
    assign res.shock  = acc_shock_reg[47:16];
    assign res.react  = acc_react_reg[47:16];
    assign res.status = status_reg;

endmodule
